[hdl/replica_exchange_permutation_top_assert.svh]
// Assertion macros for the replica-exchange engine.
`ifndef REPLICA_EXCHANGE_PERMUTATION_TOP_ASSERT_SVH
`define REPLICA_EXCHANGE_PERMUTATION_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RXP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("replica exchange assertion failed");

// Next-cycle implication, checked outside reset.
`define RXP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("replica exchange assertion failed");

`endif

[hdl/rxp_pkg.sv]
`default_nettype none
package rxp_pkg;

  localparam int REPLICAS  = 16;
  localparam int FRAC_BITS = 16;

  localparam int ADDR_W = $clog2(REPLICAS);
  localparam int IDX_W  = 4;
  localparam int MODE_W = 2;
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int TT_W   = DATA_W + FRAC_BITS;

  localparam logic [MODE_W-1:0] MODE_BETA   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENERGY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXCH   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

  // one-hot step commands from the controller
  typedef struct packed {
    logic load;
    logic rd1;
    logic rd2;
    logic dif;
    logic mul;
    logic dec;
    logic wr1;
    logic wr2;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic exch;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

[hdl/rxp_ctrl.sv]
`default_nettype none
module rxp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  rxp_pkg::status_t   status,
  output rxp_pkg::cmd_t      cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD1  = 4'd1;
  localparam logic [3:0] ST_RD2  = 4'd2;
  localparam logic [3:0] ST_DIF  = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_DEC  = 4'd5;
  localparam logic [3:0] ST_WR1  = 4'd6;
  localparam logic [3:0] ST_WR2  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RD1;
        end
      end
      ST_RD1: begin
        cmd.rd1 = 1'b1;
        // writes, reads and bad items finish straight away
        if (status.bad || !status.exch) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_RD2;
        end
      end
      ST_RD2: begin
        cmd.rd2    = 1'b1;
        state_next = ST_DIF;
      end
      ST_DIF: begin
        cmd.dif    = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DEC;
      end
      ST_DEC: begin
        cmd.dec    = 1'b1;
        state_next = ST_WR1;
      end
      ST_WR1: begin
        cmd.wr1    = 1'b1;
        state_next = ST_WR2;
      end
      ST_WR2: begin
        cmd.wr2    = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!status.out_busy) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/rxp_datapath.sv]
`default_nettype none
module rxp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  rxp_pkg::cmd_t                       cmd,
  output rxp_pkg::status_t                    status,
  input  logic        [rxp_pkg::MODE_W-1:0]   mode,
  input  logic        [rxp_pkg::IDX_W-1:0]    index,
  input  logic signed [rxp_pkg::DATA_W-1:0]   value,
  input  logic        [rxp_pkg::DATA_W-1:0]   threshold,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                accepted,
  output logic        [rxp_pkg::IDX_W-1:0]    process_at_slot,
  output logic        [rxp_pkg::IDX_W-1:0]    slot_of_process,
  output logic        [rxp_pkg::DATA_W-1:0]   accept_count,
  output logic                                bad_index
);

  localparam int AW = rxp_pkg::ADDR_W;
  localparam int DW = rxp_pkg::DATA_W;
  localparam int NR = rxp_pkg::REPLICAS;

  // item registers
  logic        [rxp_pkg::MODE_W-1:0] it_mode;
  logic        [rxp_pkg::IDX_W-1:0]  it_idx;
  logic signed [DW-1:0]              it_val;
  logic        [DW-1:0]              it_thr;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_mode <= mode;
      it_idx  <= index;
      it_val  <= value;
      it_thr  <= threshold;
    end
  end

  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] cnt_addr;
  logic [DW-1:0] limit;
  logic          bad;
  logic          last;
  logic          exch;

  assign exch     = (it_mode == rxp_pkg::MODE_EXCH);
  assign addr_a   = AW'(it_idx);
  assign addr_b   = addr_a + AW'(1);
  assign limit    = exch ? DW'(NR - 1) : DW'(NR);
  assign bad      = (DW'(it_idx) >= limit);
  assign last     = (DW'(it_idx) == DW'(NR - 1));
  assign cnt_addr = last ? '0 : addr_a;

  // tables
  logic        [AW-1:0] ptab_mem   [NR];
  logic        [AW-1:0] stab_mem   [NR];
  logic signed [DW-1:0] beta_mem   [NR];
  logic signed [DW-1:0] energy_mem [NR];
  logic        [DW-1:0] cnt_mem    [NR-1];
  logic        [NR-1:0] ptab_vld;
  logic        [NR-1:0] stab_vld;
  logic        [NR-2:0] cnt_vld;

  // read data
  logic        [AW-1:0] ptab_a_q;
  logic        [AW-1:0] ptab_b_q;
  logic        [AW-1:0] stab_q;
  logic        [DW-1:0] cnt_q;
  logic                 pva_q;
  logic                 pvb_q;
  logic                 sv_q;
  logic                 cv_q;
  logic signed [DW-1:0] beta_a_q;
  logic signed [DW-1:0] beta_b_q;
  logic signed [DW-1:0] ea_q;
  logic signed [DW-1:0] eb_q;

  // exchange pipeline
  logic [AW-1:0]                 pa_q;
  logic [AW-1:0]                 pb_q;
  logic                          db_neg_q;
  logic [DW-1:0]                 mag_db_q;
  logic                          de_neg_q;
  logic [DW-1:0]                 mag_de_q;
  logic [rxp_pkg::PROD_W-1:0]    prod_q;
  logic                          neg_q;
  logic                          ok_q;

  logic [AW-1:0]                 p_a_eff;
  logic [AW-1:0]                 p_b_eff;
  logic [AW-1:0]                 stab_eff;
  logic [DW-1:0]                 cnt_eff;
  logic [DW-1:0]                 cnt_inc;
  logic [rxp_pkg::TT_W-1:0]      tt;
  logic                          swap;

  // unwritten permutation entries read as identity, counters as zero
  assign p_a_eff  = pva_q ? ptab_a_q : addr_a;
  assign p_b_eff  = pvb_q ? ptab_b_q : addr_b;
  assign stab_eff = sv_q  ? stab_q   : addr_a;
  assign cnt_eff  = cv_q  ? cnt_q    : '0;
  assign cnt_inc  = (cnt_eff == '1) ? cnt_eff : cnt_eff + DW'(1);
  assign tt       = {it_thr, {rxp_pkg::FRAC_BITS{1'b0}}};
  assign swap     = ok_q && exch;

  always_ff @(posedge clk) begin
    if (cmd.rd1) begin
      ptab_a_q <= ptab_mem[addr_a];
      ptab_b_q <= ptab_mem[addr_b];
      stab_q   <= stab_mem[addr_a];
      cnt_q    <= cnt_mem[cnt_addr];
      pva_q    <= ptab_vld[addr_a];
      pvb_q    <= ptab_vld[addr_b];
      sv_q     <= stab_vld[addr_a];
      cv_q     <= cnt_vld[cnt_addr] && !last;
      beta_a_q <= beta_mem[addr_a];
      beta_b_q <= beta_mem[addr_b];
    end
    if (cmd.rd2) begin
      ea_q <= energy_mem[p_a_eff];
      eb_q <= energy_mem[p_b_eff];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd2) begin
      pa_q     <= p_a_eff;
      pb_q     <= p_b_eff;
      // true difference is below 2^32 in size, so 32-bit wrap is exact
      db_neg_q <= (beta_b_q < beta_a_q);
      mag_db_q <= (beta_b_q < beta_a_q) ? DW'(beta_a_q - beta_b_q)
                                        : DW'(beta_b_q - beta_a_q);
    end
    if (cmd.dif) begin
      de_neg_q <= (eb_q < ea_q);
      mag_de_q <= (eb_q < ea_q) ? DW'(ea_q - eb_q) : DW'(eb_q - ea_q);
    end
    if (cmd.mul) begin
      prod_q <= rxp_pkg::PROD_W'(mag_db_q) * rxp_pkg::PROD_W'(mag_de_q);
      neg_q  <= db_neg_q ^ de_neg_q;
    end
    if (cmd.dec) begin
      // dB*dE + t > 0 with t aligned to the product's fraction
      if (prod_q == '0 || !neg_q) begin
        ok_q <= (prod_q != '0) || (it_thr != '0);
      end else begin
        ok_q <= (rxp_pkg::PROD_W'(tt) > prod_q);
      end
    end
  end

  // table writes, one per table per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr1 && swap) begin
      ptab_mem[addr_a] <= pb_q;
      stab_mem[pa_q]   <= addr_b;
      cnt_mem[addr_a]  <= cnt_inc;
    end
    if (cmd.wr2 && swap) begin
      ptab_mem[addr_b] <= pa_q;
      stab_mem[pb_q]   <= addr_a;
    end
    if (cmd.rd1 && !bad && it_mode == rxp_pkg::MODE_BETA) begin
      beta_mem[addr_a] <= it_val;
    end
    if (cmd.rd1 && !bad && it_mode == rxp_pkg::MODE_ENERGY) begin
      energy_mem[addr_a] <= it_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptab_vld <= '0;
      stab_vld <= '0;
      cnt_vld  <= '0;
    end else begin
      if (cmd.wr1 && swap) begin
        ptab_vld[addr_a] <= 1'b1;
        stab_vld[pa_q]   <= 1'b1;
        cnt_vld[addr_a]  <= 1'b1;
      end
      if (cmd.wr2 && swap) begin
        ptab_vld[addr_b] <= 1'b1;
        stab_vld[pb_q]   <= 1'b1;
      end
    end
  end

  // result register
  logic [AW-1:0] slot_new;

  always_comb begin
    if (!swap) begin
      slot_new = stab_eff;
    end else if (addr_a == pa_q) begin
      slot_new = addr_b;
    end else if (addr_a == pb_q) begin
      slot_new = addr_a;
    end else begin
      slot_new = stab_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.fin) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      if (bad) begin
        accepted        <= 1'b0;
        process_at_slot <= '0;
        slot_of_process <= '0;
        accept_count    <= '0;
        bad_index       <= 1'b1;
      end else begin
        accepted        <= swap;
        process_at_slot <= rxp_pkg::IDX_W'(swap ? pb_q : p_a_eff);
        slot_of_process <= rxp_pkg::IDX_W'(slot_new);
        accept_count    <= last ? '0 : (swap ? cnt_inc : cnt_eff);
        bad_index       <= 1'b0;
      end
    end
  end

  assign status.bad      = bad;
  assign status.exch     = exch;
  assign status.out_busy = result_valid && result_stall;

endmodule
`default_nettype wire

[hdl/replica_exchange_permutation_top.sv]
// Replica-exchange engine for parallel tempering with 16 temperature slots.
// Input words (mode, index, value, threshold) arrive on item_valid/item_stall;
// one result word per input leaves on result_valid/result_stall.
// Mode 0 writes the beta of a slot, mode 1 the energy of a process, mode 2
// tries to swap the processes of slots index and index+1, mode 3 reads back.
// A write, a read and an out-of-range item pass the load, slot-read and finish
// steps before result_valid rises; an exchange runs slot reads, energy reads,
// difference, 32x32 multiply, compare and two table writes before finishing.
// One word is in flight at a time, so the input is held off until the last
// word has finished.
// The result sits in an output register; the next input word is taken while
// it waits, and only the finish step waits for the receiver to drop stall.
// Reset (rst, synchronous) restores the identity permutation and clears the
// acceptance counters at once through per-entry valid bits; betas and
// energies are undefined until written. No clearing pass is needed.
`default_nettype none
module replica_exchange_permutation_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic        [rxp_pkg::MODE_W-1:0]   mode,
  input  logic        [rxp_pkg::IDX_W-1:0]    index,
  input  logic signed [rxp_pkg::DATA_W-1:0]   value,
  input  logic        [rxp_pkg::DATA_W-1:0]   threshold,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                accepted,
  output logic        [rxp_pkg::IDX_W-1:0]    process_at_slot,
  output logic        [rxp_pkg::IDX_W-1:0]    slot_of_process,
  output logic        [rxp_pkg::DATA_W-1:0]   accept_count,
  output logic                                bad_index
);

  rxp_pkg::cmd_t    cmd;
  rxp_pkg::status_t status;
  logic             res_clear;

  // sequencer: one state per step of the exchange
  rxp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // tables, exchange arithmetic and result register
  rxp_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .mode            (mode),
    .index           (index),
    .value           (value),
    .threshold       (threshold),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .accepted        (accepted),
    .process_at_slot (process_at_slot),
    .slot_of_process (slot_of_process),
    .accept_count    (accept_count),
    .bad_index       (bad_index)
  );

  // every field but bad_index is zero
  assign res_clear = !accepted && (accept_count == '0) && (process_at_slot == '0) &&
                     (slot_of_process == '0);

`include "replica_exchange_permutation_top_assert.svh"

  // a taken word holds the input off while it is worked on
  `RXP_ASSERT_NEXT(a_busy_after_take, clk, rst, item_valid && !item_stall, item_stall)
  // at most one step command per cycle
  `RXP_ASSERT_IMPL(a_one_step, clk, rst, 1'b1, $onehot0(cmd))
  // the result register is never overwritten while the receiver holds it
  `RXP_ASSERT_IMPL(a_fin_free, clk, rst, cmd.fin, !(result_valid && result_stall))
  // a rejected index reports nothing else
  `RXP_ASSERT_IMPL(a_bad_clean, clk, rst, result_valid && bad_index, res_clear)

endmodule
`default_nettype wire
